>>> rtl/rational_arithmetic_unit_macros.svh
// Assertion macros for the rational arithmetic unit checker.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// check cons in the cycle after ante, outside reset
`define RAU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// check cons in the cycle after reset is seen
`define RAU_ASSERT_RST(label, cons, msg) \
    label: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) else $error(msg);

`endif

>>> rtl/rau_pkg.sv
// Package for the rational arithmetic unit: widths, opcodes, states,
// and the command and status structs between controller and datapath.
package rau_pkg;

    localparam int DATA_W = 64;
    localparam int HALF_W = DATA_W / 2;
    localparam int OP_W   = 3;

    localparam logic [OP_W-1:0] OP_ADD  = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd3;
    localparam logic [OP_W-1:0] OP_NEG  = 3'd4;
    localparam logic [OP_W-1:0] OP_SIMP = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MUL,
        S_GCD,
        S_DIV,
        S_DONE
    } t_rau_state;

    typedef struct packed {
        logic       load_in;
        logic       mul_go;
        logic       mul_acc;
        logic [1:0] pair;
        logic [1:0] half;
        logic       gcd_init;
        logic       gcd_step;
        logic       div_init;
        logic       div_step;
        logic       load_out;
    } t_rau_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            simp_ok;
        logic            gcd_done;
    } t_rau_sts;

endpackage

>>> rtl/rau_in_if.sv
// Input channel of the rational arithmetic unit: handshake and operands.
// Depends on rau_pkg.
interface rau_in_if;
    import rau_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] a_num;
    logic [DATA_W-1:0] a_den;
    logic [DATA_W-1:0] b_num;
    logic [DATA_W-1:0] b_den;

    modport source (output valid, op, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, op, a_num, a_den, b_num, b_den, output ready);
endinterface

>>> rtl/rau_out_if.sv
// Output channel of the rational arithmetic unit: handshake and result.
// Depends on rau_pkg.
interface rau_out_if;
    import rau_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] res_num;
    logic [DATA_W-1:0] res_den;

    modport source (output valid, res_num, res_den, input ready);
    modport sink   (input valid, res_num, res_den, output ready);
endinterface

>>> rtl/rau_ctrl.sv
// Controller of the rational arithmetic unit: sequences multiply, GCD
// and divide steps and owns both handshakes. Depends on rau_pkg.
module rau_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  rau_pkg::t_rau_sts i_sts,
    output rau_pkg::t_rau_cmd o_cmd
);
    import rau_pkg::*;

    t_rau_state r_state, n_state;
    logic [2:0] r_sub;
    logic [1:0] r_pair;
    logic [5:0] r_cnt;
    logic       r_out_valid;
    logic       w_arith;
    logic       w_mul_last;
    logic       w_div_last;

    assign w_arith = (i_sts.op == OP_ADD) || (i_sts.op == OP_SUB) ||
                     (i_sts.op == OP_MUL) || (i_sts.op == OP_DIV);
    assign w_mul_last = (r_sub == 3'd5) && (r_pair == 2'd2);
    assign w_div_last = (r_cnt == 6'd63);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (w_arith) n_state = S_MUL;
                else if (i_sts.op == OP_SIMP && i_sts.simp_ok) n_state = S_GCD;
                else n_state = S_DONE;
            end
            S_MUL: begin
                if (w_mul_last) n_state = S_DONE;
            end
            S_GCD: begin
                if (i_sts.gcd_done) n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            S_DECODE: begin
                o_cmd.gcd_init = !w_arith && (i_sts.op == OP_SIMP) && i_sts.simp_ok;
            end
            S_MUL: begin
                o_cmd.mul_go  = !r_sub[0];
                o_cmd.mul_acc = r_sub[0];
                o_cmd.pair    = r_pair;
                o_cmd.half    = r_sub[2:1];
            end
            S_GCD: begin
                o_cmd.div_init = i_sts.gcd_done;
                o_cmd.gcd_step = !i_sts.gcd_done;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            S_DONE: begin
                o_cmd.load_out = !r_out_valid || i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sub       <= '0;
            r_pair      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DECODE) begin
                r_sub  <= '0;
                r_pair <= '0;
                r_cnt  <= '0;
            end
            if (r_state == S_MUL) begin
                if (r_sub == 3'd5) begin
                    r_sub  <= '0;
                    r_pair <= r_pair + 2'd1;
                end else begin
                    r_sub <= r_sub + 3'd1;
                end
            end
            if (r_state == S_DIV) r_cnt <= r_cnt + 6'd1;
            if (o_cmd.load_out) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/rau_dp.sv
// Datapath of the rational arithmetic unit: shared 32x32 multiplier,
// binary GCD loop, two restoring dividers, result register. Depends on rau_pkg.
module rau_dp (
    input  logic                      i_clk,
    input  rau_pkg::t_rau_cmd         i_cmd,
    output rau_pkg::t_rau_sts         o_sts,
    input  logic [rau_pkg::OP_W-1:0]  i_op,
    input  logic [rau_pkg::DATA_W-1:0] i_a_num,
    input  logic [rau_pkg::DATA_W-1:0] i_a_den,
    input  logic [rau_pkg::DATA_W-1:0] i_b_num,
    input  logic [rau_pkg::DATA_W-1:0] i_b_den,
    output logic [rau_pkg::DATA_W-1:0] o_res_num,
    output logic [rau_pkg::DATA_W-1:0] o_res_den
);
    import rau_pkg::*;

    logic [OP_W-1:0]     r_op;
    logic [DATA_W-1:0]   r_an, r_ad, r_bn, r_bd;
    logic [DATA_W-1:0]   r_p0, r_p1, r_p2, r_pp;
    logic [DATA_W-1:0]   r_gx, r_gy, r_g;
    logic [5:0]          r_gk;
    logic [DATA_W-1:0]   r_qn, r_qd, r_rn, r_rd;
    logic [DATA_W-1:0]   r_res_num, r_res_den;

    logic [DATA_W-1:0]   w_ma, w_mb, w_sel_p, w_acc;
    logic [HALF_W-1:0]   w_ha, w_hb;
    logic [DATA_W-1:0]   w_mag_an, w_mag_ad, w_mx;
    logic [DATA_W:0]     w_tn, w_td, w_dn, w_dd;
    logic [DATA_W-1:0]   w_sn, w_sd, n_res_num, n_res_den;

    assign w_mag_an = r_an[DATA_W-1] ? (-r_an) : r_an;
    assign w_mag_ad = r_ad[DATA_W-1] ? (-r_ad) : r_ad;
    assign w_mx     = ($signed(r_an) > $signed(r_ad)) ? r_an : r_ad;

    assign o_sts.op       = r_op;
    assign o_sts.simp_ok  = (r_ad != '0) && ($signed(w_mx) > $signed(64'sd1));
    assign o_sts.gcd_done = (r_gy == '0);

    always_comb begin
        w_ma = r_an;
        w_mb = r_bd;
        case (i_cmd.pair)
            2'd0: begin
                w_ma = r_an;
                w_mb = (r_op == OP_MUL) ? r_bn : r_bd;
            end
            2'd1: begin
                w_ma = r_bn;
                w_mb = r_ad;
            end
            default: begin
                w_ma = r_ad;
                w_mb = (r_op == OP_DIV) ? r_bn : r_bd;
            end
        endcase
        case (i_cmd.half)
            2'd0: begin
                w_ha = w_ma[HALF_W-1:0];
                w_hb = w_mb[HALF_W-1:0];
            end
            2'd1: begin
                w_ha = w_ma[HALF_W-1:0];
                w_hb = w_mb[DATA_W-1:HALF_W];
            end
            default: begin
                w_ha = w_ma[DATA_W-1:HALF_W];
                w_hb = w_mb[HALF_W-1:0];
            end
        endcase
        case (i_cmd.pair)
            2'd0:    w_sel_p = r_p0;
            2'd1:    w_sel_p = r_p1;
            default: w_sel_p = r_p2;
        endcase
        w_acc = (i_cmd.half == 2'd0) ? r_pp
                                     : w_sel_p + {r_pp[HALF_W-1:0], {HALF_W{1'b0}}};
    end

    assign w_tn = {r_rn, r_qn[DATA_W-1]};
    assign w_td = {r_rd, r_qd[DATA_W-1]};
    assign w_dn = w_tn - {1'b0, r_g};
    assign w_dd = w_td - {1'b0, r_g};

    assign w_sn = r_an[DATA_W-1] ? (-r_qn) : r_qn;
    assign w_sd = r_ad[DATA_W-1] ? (-r_qd) : r_qd;

    always_comb begin
        n_res_num = r_an;
        n_res_den = r_ad;
        case (r_op)
            OP_ADD: begin
                n_res_num = r_p0 + r_p1;
                n_res_den = r_p2;
            end
            OP_SUB: begin
                n_res_num = r_p0 - r_p1;
                n_res_den = r_p2;
            end
            OP_MUL, OP_DIV: begin
                n_res_num = r_p0;
                n_res_den = r_p2;
            end
            OP_NEG: begin
                n_res_num = -r_an;
            end
            OP_SIMP: begin
                if (o_sts.simp_ok) begin
                    n_res_num = w_sn;
                    n_res_den = w_sd;
                end
            end
            default: begin
                n_res_num = r_an;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op <= i_op;
            r_an <= i_a_num;
            r_ad <= i_a_den;
            r_bn <= i_b_num;
            r_bd <= i_b_den;
        end
        if (i_cmd.mul_go) r_pp <= w_ha * w_hb;
        if (i_cmd.mul_acc) begin
            case (i_cmd.pair)
                2'd0:    r_p0 <= w_acc;
                2'd1:    r_p1 <= w_acc;
                default: r_p2 <= w_acc;
            endcase
        end
        if (i_cmd.gcd_init) begin
            r_gx <= w_mag_an;
            r_gy <= w_mag_ad;
            r_gk <= '0;
        end else if (i_cmd.gcd_step) begin
            if (r_gx == '0) begin
                r_gx <= r_gy;
                r_gy <= '0;
            end else if (!r_gx[0] && !r_gy[0]) begin
                r_gx <= r_gx >> 1;
                r_gy <= r_gy >> 1;
                r_gk <= r_gk + 6'd1;
            end else if (!r_gx[0]) begin
                r_gx <= r_gx >> 1;
            end else if (!r_gy[0]) begin
                r_gy <= r_gy >> 1;
            end else if (r_gx >= r_gy) begin
                r_gx <= r_gx - r_gy;
            end else begin
                r_gy <= r_gy - r_gx;
            end
        end
        if (i_cmd.div_init) begin
            r_g  <= r_gx << r_gk;
            r_qn <= w_mag_an;
            r_qd <= w_mag_ad;
            r_rn <= '0;
            r_rd <= '0;
        end else if (i_cmd.div_step) begin
            if (!w_dn[DATA_W]) begin
                r_rn <= w_dn[DATA_W-1:0];
                r_qn <= {r_qn[DATA_W-2:0], 1'b1};
            end else begin
                r_rn <= w_tn[DATA_W-1:0];
                r_qn <= {r_qn[DATA_W-2:0], 1'b0};
            end
            if (!w_dd[DATA_W]) begin
                r_rd <= w_dd[DATA_W-1:0];
                r_qd <= {r_qd[DATA_W-2:0], 1'b1};
            end else begin
                r_rd <= w_td[DATA_W-1:0];
                r_qd <= {r_qd[DATA_W-2:0], 1'b0};
            end
        end
        if (i_cmd.load_out) begin
            r_res_num <= n_res_num;
            r_res_den <= n_res_den;
        end
    end

    assign o_res_num = r_res_num;
    assign o_res_den = r_res_den;

endmodule

>>> rtl/rational_arithmetic_unit.sv
// Rational arithmetic unit top level. Depends on rau_pkg, rau_in_if, rau_out_if, rau_ctrl, rau_dp.
// From accept to result valid: negate, pass-through and an inapplicable simplify go from decode to
// done; add, subtract, multiply and divide form nine 32x32 partial products on one multiplier;
// simplify runs the binary GCD loop, one GCD step per cycle, then the two restoring dividers.
// Throughput: one item in flight; the next is accepted in the cycle after the result is loaded,
// later while the previous result is still held. Reset: synchronous, active low; clears the
// controller and output valid.
module rational_arithmetic_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    rau_in_if.sink    i_in,
    rau_out_if.source o_out
);
    import rau_pkg::*;

    t_rau_cmd w_cmd;
    t_rau_sts w_sts;

    rau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    rau_dp u_dp (
        .i_clk     (i_clk),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .i_op      (i_in.op),
        .i_a_num   (i_in.a_num),
        .i_a_den   (i_in.a_den),
        .i_b_num   (i_in.b_num),
        .i_b_den   (i_in.b_den),
        .o_res_num (o_out.res_num),
        .o_res_den (o_out.res_den)
    );

endmodule

>>> rtl/rau_checker.sv
// Port-level checker for the rational arithmetic unit, bound to the top.
// Depends on rational_arithmetic_unit_macros.svh.
`include "rational_arithmetic_unit_macros.svh"

module rau_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);

    `RAU_ASSERT_NEXT(a_in_busy, i_in_valid && i_in_ready, !i_in_ready, "ready after accept")
    `RAU_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "result dropped")
    `RAU_ASSERT_RST(a_rst_idle, !i_out_valid && i_in_ready, "not idle after reset")

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready)
);

>>> bench/rational_arithmetic_unit_tb.sv
// Self-checking bench for rational_arithmetic_unit: directed and random items,
// each result checked against an in-bench rational predictor.
// Depends on rau_pkg, rau_in_if, rau_out_if and the top level.
module rational_arithmetic_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rau_pkg::*;

    localparam logic [OP_W-1:0] OP_PASS6 = 3'd6;
    localparam logic [OP_W-1:0] OP_PASS7 = 3'd7;
    localparam logic [DATA_W-1:0] W_MIN  = 64'h8000_0000_0000_0000;
    localparam logic [DATA_W-1:0] W_MAX  = 64'h7fff_ffff_ffff_ffff;
    localparam logic [DATA_W-1:0] W_ONES = 64'hffff_ffff_ffff_ffff;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] a_num;
        logic [DATA_W-1:0] a_den;
        logic [DATA_W-1:0] b_num;
        logic [DATA_W-1:0] b_den;
    } t_operands;

    typedef struct packed {
        logic [DATA_W-1:0] num;
        logic [DATA_W-1:0] den;
    } t_ratio;

    logic i_clk;
    logic i_rst_n;
    rau_in_if  in_ch();
    rau_out_if out_ch();

    rational_arithmetic_unit i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    t_ratio pending_ratios[$];
    bit     failed;
    bit     no_idle;
    int     cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("rational_arithmetic_unit verification failed");
            $finish;
        end
    end

    function automatic logic [DATA_W-1:0] magnitude(logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? -v : v;
    endfunction

    function automatic logic [DATA_W-1:0] gcd_of(logic [DATA_W-1:0] x,
                                                  logic [DATA_W-1:0] y);
        logic [DATA_W-1:0] t;
        while (y != '0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic logic [DATA_W-1:0] div_signed(logic [DATA_W-1:0] v,
                                                      logic [DATA_W-1:0] g);
        logic [DATA_W-1:0] m;
        m = magnitude(v) / g;
        return v[DATA_W-1] ? -m : m;
    endfunction

    function automatic t_ratio predict_ratio(t_operands it);
        t_ratio r;
        logic [DATA_W-1:0] mx, g;
        r.num = it.a_num;
        r.den = it.a_den;
        case (it.op)
            OP_ADD: begin
                r.den = it.a_den * it.b_den;
                r.num = it.a_num * it.b_den + it.b_num * it.a_den;
            end
            OP_SUB: begin
                r.den = it.a_den * it.b_den;
                r.num = it.a_num * it.b_den - it.b_num * it.a_den;
            end
            OP_MUL: begin
                r.den = it.a_den * it.b_den;
                r.num = it.a_num * it.b_num;
            end
            OP_DIV: begin
                r.den = it.a_den * it.b_num;
                r.num = it.a_num * it.b_den;
            end
            OP_NEG: r.num = -it.a_num;
            OP_SIMP: begin
                mx = ($signed(it.a_num) > $signed(it.a_den)) ? it.a_num : it.a_den;
                if (it.a_den != '0 && !mx[DATA_W-1] && mx > 1) begin
                    g = gcd_of(magnitude(it.a_num), magnitude(it.a_den));
                    if (g > 1) begin
                        r.num = div_signed(it.a_num, g);
                        r.den = div_signed(it.a_den, g);
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic logic [DATA_W-1:0] rand_word();
        logic [DATA_W-1:0] w;
        case ($urandom_range(0, 5))
            0, 1: w = {$urandom, $urandom};
            2: w = 64'($signed($urandom_range(0, 40)) - 20);
            3: w = 64'(1) << $urandom_range(0, 63);
            4: begin
                case ($urandom_range(0, 4))
                    0: w = W_MIN;
                    1: w = W_MAX;
                    2: w = W_ONES;
                    3: w = '0;
                    default: w = 64'd1;
                endcase
            end
            default: w = 64'($urandom_range(0, 100000));
        endcase
        return w;
    endfunction

    task automatic send_item(t_operands it);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op    <= it.op;
        in_ch.a_num <= it.a_num;
        in_ch.a_den <= it.a_den;
        in_ch.b_num <= it.b_num;
        in_ch.b_den <= it.b_den;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_ratios.push_back(predict_ratio(it));
    endtask

    task automatic send_ops(logic [OP_W-1:0] op, logic [DATA_W-1:0] an,
                            logic [DATA_W-1:0] ad, logic [DATA_W-1:0] bn,
                            logic [DATA_W-1:0] bd);
        t_operands it;
        it = '{op, an, ad, bn, bd};
        send_item(it);
    endtask

    // Result side: random stalls, compare against oldest expectation
    initial begin
        t_ratio exp_r;
        int stall;
        out_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
            if (pending_ratios.size() == 0) begin
                $error("unexpected result num=%h den=%h", out_ch.res_num, out_ch.res_den);
                failed = 1'b1;
            end else begin
                exp_r = pending_ratios.pop_front();
                if (out_ch.res_num !== exp_r.num) begin
                    $error("res_num expected %h actual %h", exp_r.num, out_ch.res_num);
                    failed = 1'b1;
                end
                if (out_ch.res_den !== exp_r.den) begin
                    $error("res_den expected %h actual %h", exp_r.den, out_ch.res_den);
                    failed = 1'b1;
                end
            end
        end
    end

    task automatic test_every_op();
        send_ops(OP_ADD, 64'd1, 64'd2, 64'd1, 64'd3);
        send_ops(OP_SUB, 64'd1, 64'd2, 64'd1, 64'd3);
        send_ops(OP_MUL, -64'd3, 64'd4, 64'd5, -64'd7);
        send_ops(OP_DIV, 64'd3, 64'd4, 64'd5, 64'd7);
        send_ops(OP_NEG, 64'd9, 64'd2, W_ONES, W_ONES);
        send_ops(OP_SIMP, 64'd12, 64'd18, W_MAX, W_MIN);
        send_ops(OP_PASS6, 64'd5, 64'd6, 64'd7, 64'd8);
        send_ops(OP_PASS7, W_MIN, W_MAX, 64'd7, 64'd8);
    endtask

    task automatic test_extremes();
        send_ops(OP_ADD, W_MAX, W_MAX, W_MAX, W_MAX);
        send_ops(OP_SUB, W_MIN, W_MAX, W_MAX, W_MIN);
        send_ops(OP_MUL, W_MIN, W_MIN, W_ONES, W_ONES);
        send_ops(OP_DIV, W_ONES, W_MAX, W_MIN, '0);
        send_ops(OP_ADD, '0, '0, '0, '0);
        send_ops(OP_MUL, W_MAX, W_ONES, W_MIN, W_MAX);
    endtask

    task automatic test_special_cases();
        send_ops(OP_NEG, W_MIN, 64'd1, '0, '0);
        send_ops(OP_SIMP, 64'd6, '0, '0, '0);
        send_ops(OP_SIMP, -64'd6, -64'd9, '0, '0);
        send_ops(OP_SIMP, 64'd1, 64'd1, '0, '0);
        send_ops(OP_SIMP, '0, 64'd7, '0, '0);
        send_ops(OP_SIMP, -64'd8, 64'd12, '0, '0);
        send_ops(OP_SIMP, 64'd10, -64'd4, '0, '0);
        send_ops(OP_SIMP, W_MIN, W_MAX, '0, '0);
        send_ops(OP_SIMP, W_MAX, W_MIN, '0, '0);
        send_ops(OP_SIMP, 64'd13, 64'd7, '0, '0);
        send_ops(OP_DIV, 64'd1, 64'd2, '0, 64'd5);
    endtask

    task automatic test_random(int count);
        t_operands it;
        logic [DATA_W-1:0] k;
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
            it.op    = OP_W'($urandom_range(0, 7));
            it.a_num = rand_word();
            it.a_den = rand_word();
            it.b_num = rand_word();
            it.b_den = rand_word();
            if ($urandom_range(0, 2) == 0) it.op = OP_SIMP;
            if (it.op == OP_SIMP && $urandom_range(0, 3) != 0) begin
                k = 64'($urandom_range(2, 5000));
                it.a_num = k * 64'($signed($urandom_range(0, 200000)) - 100000);
                it.a_den = k * 64'($urandom_range(1, 100000));
                if ($urandom_range(0, 3) == 0) it.a_den = -it.a_den;
            end
            send_item(it);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        failed       = 1'b0;
        no_idle      = 1'b0;
        cycle_count  = 0;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.op     = OP_ADD;
        in_ch.a_num  = '0;
        in_ch.a_den  = '0;
        in_ch.b_num  = '0;
        in_ch.b_den  = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_every_op();
        test_extremes();
        test_special_cases();
        test_random(1250);
        in_ch.valid <= 1'b0;
        while (pending_ratios.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failed) begin
            $display("rational_arithmetic_unit verification failed");
        end else begin
            $display("rational_arithmetic_unit verification clean");
        end
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl
rtl/rau_pkg.sv
rtl/rau_in_if.sv
rtl/rau_out_if.sv
rtl/rau_ctrl.sv
rtl/rau_dp.sv
rtl/rational_arithmetic_unit.sv
rtl/rau_checker.sv
bench/rational_arithmetic_unit_tb.sv
